/* rtl/stereo_gain_and_mono_resampler_defines.svh */
// Assertion macros shared by the resampler RTL.
`ifndef STEREO_GAIN_AND_MONO_RESAMPLER_DEFINES_SVH
`define STEREO_GAIN_AND_MONO_RESAMPLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGMR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SGMR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sgmr_pkg.sv */
package sgmr_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 15;
    localparam int STEP_W     = 19;
    localparam int PHASE_W    = 20;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 19;

    localparam int MAX_REF_PER_FRAME_DEF = 8;

    localparam logic [GAIN_W-1:0]  GAIN_UNITY = 15'h7FFF;
    localparam logic [STEP_W-1:0]  STEP_RESET = 19'h10000;
    localparam logic [PHASE_W-1:0] ONE_Q16    = 20'h10000;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MUTE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_ENABLE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP       = 2'd3;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MULT  = 8'b0000_0010,
        S_SCALE = 8'b0000_0100,
        S_MONO  = 8'b0000_1000,
        S_CHECK = 8'b0001_0000,
        S_PROD  = 8'b0010_0000,
        S_SUM   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic load;
        logic mult;
        logic scale;
        logic mono;
        logic diff;
        logic prod;
        logic emit_ref;
        logic emit_none;
        logic first;
        logic last;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic ref_enable;
        logic phase_lt_one;
        logic next_lt_one;
    } t_stat;

endpackage

/* rtl/stereo_gain_and_mono_resampler.sv */
// Stereo gain stage with a mono reference resampler. Each accepted request
// is one stereo frame; the block returns one or more results per frame, the
// first carrying the scaled (or muted) frame and each carrying at most one
// linearly interpolated mono reference sample, with last marking the final
// result of the frame. With the reference path on, a frame yields up to
// MAX_REF_PER_FRAME reference samples, or none. The controller steps one
// frame at a time through the gain multiply, the saturation, the mono sum
// and, per reference sample, one interpolation multiply, one add and one
// output handshake, which the result side can stall. Configuration must be
// written only while the block is idle; the block itself does not enforce
// this. Writing ref_enable or the step register restarts the phase.
module stereo_gain_and_mono_resampler import sgmr_pkg::*; #(
    parameter int MAX_REF_PER_FRAME = MAX_REF_PER_FRAME_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [SAMPLE_W-1:0] i_left_in,
    input  logic signed [SAMPLE_W-1:0] i_right_in,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_play_valid,
    output logic signed [SAMPLE_W-1:0] o_play_left,
    output logic signed [SAMPLE_W-1:0] o_play_right,
    output logic                       o_ref_valid,
    output logic signed [SAMPLE_W-1:0] o_ref_sample,
    output logic                       o_last
);

    t_cmd  w_cmd;
    t_stat w_stat;

    sgmr_ctrl #(
        .MAX_REF_PER_FRAME (MAX_REF_PER_FRAME)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    sgmr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_left_in    (i_left_in),
        .i_right_in   (i_right_in),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_play_valid (o_play_valid),
        .o_play_left  (o_play_left),
        .o_play_right (o_play_right),
        .o_ref_valid  (o_ref_valid),
        .o_ref_sample (o_ref_sample),
        .o_last       (o_last)
    );

endmodule

/* rtl/sgmr_ctrl.sv */
`include "stereo_gain_and_mono_resampler_defines.svh"

module sgmr_ctrl import sgmr_pkg::*; #(
    parameter int MAX_REF_PER_FRAME = MAX_REF_PER_FRAME_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam int CNT_W = $clog2(MAX_REF_PER_FRAME + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REF_PER_FRAME);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_last, n_last;
    logic             w_sum_last;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // The sample being formed is the final one when the phase leaves the
    // interval after this step or the per-frame cap is reached.
    assign w_sum_last = !i_stat.next_lt_one || ((r_cnt + CNT_W'(1)) == CNT_MAX);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_last  = r_last;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MULT;
                end
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_MONO;
            end
            S_MONO: begin
                o_cmd.mono = 1'b1;
                n_cnt      = '0;
                if (i_stat.ref_enable) begin
                    n_state = S_CHECK;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_CHECK: begin
                // The mono sample is now registered, so a frame without
                // reference output can be emitted from here.
                o_cmd.diff = 1'b1;
                if (i_stat.phase_lt_one) begin
                    n_state = S_PROD;
                end else begin
                    o_cmd.emit_none = 1'b1;
                    n_last          = 1'b1;
                    n_state         = S_OUT;
                end
            end
            S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.emit_ref = 1'b1;
                o_cmd.first    = (r_cnt == '0);
                o_cmd.last     = w_sum_last;
                n_last         = w_sum_last;
                n_cnt          = r_cnt + CNT_W'(1);
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (r_last) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_PROD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // A disabled reference path yields one result that is also the last.
        if (r_state == S_MONO && !i_stat.ref_enable) begin
            o_cmd.emit_none = 1'b1;
            n_last          = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
        end
    end

    `SGMR_ASSERT_NOW(a_ready_excl, o_out_valid, !o_in_ready, "input ready while result pending")
    `SGMR_ASSERT_NOW(a_cnt_cap, 1'b1, r_cnt <= CNT_MAX, "reference count exceeds cap")
    `SGMR_ASSERT_NEXT(a_last_frees, o_out_valid && i_out_ready && r_last, o_in_ready,
        "block not ready after final result")
    `SGMR_ASSERT_NEXT(a_accept_busy, i_in_valid && o_in_ready, !o_in_ready && !o_out_valid,
        "accepted request did not start processing")

endmodule

/* rtl/sgmr_dp.sv */
module sgmr_dp import sgmr_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic signed [SAMPLE_W-1:0] i_left_in,
    input  logic signed [SAMPLE_W-1:0] i_right_in,
    input  t_cmd                       i_cmd,
    output t_stat                      o_stat,
    output logic                       o_play_valid,
    output logic signed [SAMPLE_W-1:0] o_play_left,
    output logic signed [SAMPLE_W-1:0] o_play_right,
    output logic                       o_ref_valid,
    output logic signed [SAMPLE_W-1:0] o_ref_sample,
    output logic                       o_last
);

    localparam int PROD_W = 2 * SAMPLE_W;
    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int IPROD_W = 2 * DIFF_W;

    logic [GAIN_W-1:0]          r_gain;
    logic                       r_mute;
    logic                       r_ref_en;
    logic [STEP_W-1:0]          r_step;
    logic [PHASE_W-1:0]         r_phase;
    logic                       r_have_prev;
    logic signed [SAMPLE_W-1:0] r_prev;

    logic signed [SAMPLE_W-1:0] r_l, r_r;
    logic signed [PROD_W-1:0]   r_pl, r_pr;
    logic signed [SAMPLE_W-1:0] r_sl, r_sr;
    logic signed [SAMPLE_W-1:0] r_cur;
    logic signed [DIFF_W-1:0]   r_diff;
    logic signed [IPROD_W-1:0]  r_prod;

    logic                       r_o_play_valid;
    logic signed [SAMPLE_W-1:0] r_o_play_left, r_o_play_right;
    logic                       r_o_ref_valid;
    logic signed [SAMPLE_W-1:0] r_o_ref_sample;
    logic                       r_o_last;

    logic signed [SAMPLE_W-1:0] w_base;
    logic signed [DIFF_W-1:0]   w_mono_sum;
    logic signed [DIFF_W-1:0]   w_interp;
    logic [PHASE_W-1:0]         w_phase_add;

    // Floor of the Q15 product, clamped to the sample range.
    function automatic logic signed [SAMPLE_W-1:0] sat_q15(input logic signed [PROD_W-1:0] p);
        logic signed [SAMPLE_W:0] t;
        t = p[PROD_W-1:GAIN_W];
        if (t[SAMPLE_W] != t[SAMPLE_W-1]) begin
            sat_q15 = t[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
            sat_q15 = t[SAMPLE_W-1:0];
        end
    endfunction

    assign w_base      = r_have_prev ? r_prev : r_cur;
    assign w_mono_sum  = {r_sl[SAMPLE_W-1], r_sl} + {r_sr[SAMPLE_W-1], r_sr};
    assign w_interp    = {w_base[SAMPLE_W-1], w_base} + r_prod[IPROD_W-2:FRAC_W];
    assign w_phase_add = r_phase + {{(PHASE_W-STEP_W){1'b0}}, r_step};

    assign o_stat.ref_enable   = r_ref_en;
    assign o_stat.phase_lt_one = (r_phase < ONE_Q16);
    assign o_stat.next_lt_one  = (w_phase_add < ONE_Q16);

    assign o_play_valid = r_o_play_valid;
    assign o_play_left  = r_o_play_left;
    assign o_play_right = r_o_play_right;
    assign o_ref_valid  = r_o_ref_valid;
    assign o_ref_sample = r_o_ref_sample;
    assign o_last       = r_o_last;

    // Configuration, phase and history state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= GAIN_UNITY;
            r_mute      <= 1'b0;
            r_ref_en    <= 1'b0;
            r_step      <= STEP_RESET;
            r_phase     <= '0;
            r_have_prev <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GAIN:       r_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_MUTE:       r_mute <= i_cfg_data[0];
                CFG_REF_ENABLE: begin
                    r_ref_en <= i_cfg_data[0];
                    r_phase  <= '0;
                end
                CFG_STEP:       begin
                    r_step  <= i_cfg_data[STEP_W-1:0];
                    r_phase <= '0;
                end
                default: ;
            endcase
        end else if (i_cmd.emit_ref) begin
            r_phase <= w_phase_add;
        end else if (i_cmd.finish) begin
            if (r_ref_en) begin
                if (r_phase >= ONE_Q16) begin
                    r_phase <= r_phase - ONE_Q16;
                end
                r_have_prev <= 1'b1;
            end else begin
                r_have_prev <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && r_ref_en) begin
            r_prev <= r_cur;
        end
        if (i_cmd.load) begin
            r_l <= i_left_in;
            r_r <= i_right_in;
        end
        if (i_cmd.mult) begin
            r_pl <= r_l * $signed({1'b0, r_gain});
            r_pr <= r_r * $signed({1'b0, r_gain});
        end
        if (i_cmd.scale) begin
            if (r_mute) begin
                r_sl <= '0;
                r_sr <= '0;
            end else if (r_gain == GAIN_UNITY) begin
                r_sl <= r_l;
                r_sr <= r_r;
            end else begin
                r_sl <= sat_q15(r_pl);
                r_sr <= sat_q15(r_pr);
            end
        end
        if (i_cmd.mono) begin
            r_cur <= w_mono_sum[DIFF_W-1:1];
        end
        if (i_cmd.diff) begin
            r_diff <= {r_cur[SAMPLE_W-1], r_cur} - {w_base[SAMPLE_W-1], w_base};
        end
        if (i_cmd.prod) begin
            r_prod <= r_diff * $signed({1'b0, r_phase[FRAC_W-1:0]});
        end
        if (i_cmd.emit_ref) begin
            r_o_play_valid <= i_cmd.first;
            r_o_play_left  <= i_cmd.first ? r_sl : '0;
            r_o_play_right <= i_cmd.first ? r_sr : '0;
            r_o_ref_valid  <= 1'b1;
            r_o_ref_sample <= w_interp[SAMPLE_W-1:0];
            r_o_last       <= i_cmd.last;
        end else if (i_cmd.emit_none) begin
            r_o_play_valid <= 1'b1;
            r_o_play_left  <= r_sl;
            r_o_play_right <= r_sr;
            r_o_ref_valid  <= 1'b0;
            r_o_ref_sample <= '0;
            r_o_last       <= 1'b1;
        end
    end

endmodule

/* verif/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sgmr_pkg::*;

    localparam int MAX_REFS    = MAX_REF_PER_FRAME_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 40;
    localparam int RANDOM_FRAMES = 200;

    typedef enum logic [1:0] {PLAN_FRAME, PLAN_CFG, PLAN_DRAIN} t_plan_kind;

    typedef struct {
        t_plan_kind                 kind;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        int unsigned                gap;
        logic [CFG_IDX_W-1:0]       idx;
        logic [CFG_DATA_W-1:0]      data;
    } t_plan;

    typedef struct {
        logic                       play_valid;
        logic signed [SAMPLE_W-1:0] play_left;
        logic signed [SAMPLE_W-1:0] play_right;
        logic                       ref_valid;
        logic signed [SAMPLE_W-1:0] ref_sample;
        logic                       last;
    } t_frame_out;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_left_in = '0;
    logic signed [SAMPLE_W-1:0] i_right_in = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b1;
    logic                       o_play_valid;
    logic signed [SAMPLE_W-1:0] o_play_left;
    logic signed [SAMPLE_W-1:0] o_play_right;
    logic                       o_ref_valid;
    logic signed [SAMPLE_W-1:0] o_ref_sample;
    logic                       o_last;

    stereo_gain_and_mono_resampler u_top (.*);

    always #4 i_clk = ~i_clk;

    // Stimulus plan and the outputs predicted for accepted frames.
    t_plan      stim_plan[$];
    t_frame_out pending_outputs[$];

    // Predictor copy of the registers and of the resampler state.
    logic [GAIN_W-1:0]   m_gain;
    logic                m_mute;
    logic                m_ref_en;
    logic [STEP_W-1:0]   m_step;
    logic signed [SAMPLE_W-1:0] m_prev;
    logic                m_have_prev;
    logic [PHASE_W-1:0]  m_phase;

    int          outputs_due = 0;
    int          outputs_seen = 0;
    int          errors = 0;
    int          frames_done = 0;
    int          refs_total = 0;
    int          refs_max = 0;
    int          silent_frames = 0;
    int          cfg_writes = 0;
    int          cycle_count = 0;
    bit          staged = 1'b0;
    bit          tx_calm = 1'b0;
    int unsigned frames_planned = 0;

    function automatic int unsigned draw_wait(input bit calm);
        if (calm || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] scale_q15(
        input logic signed [SAMPLE_W-1:0] x,
        input logic [GAIN_W-1:0]          g
    );
        longint t;
        t = (longint'(x) * longint'({1'b0, g})) >>> 15;
        if (t > 32767)
            t = 32767;
        if (t < -32768)
            t = -32768;
        return t[SAMPLE_W-1:0];
    endfunction

    task automatic add_frame(input int l, input int r);
        t_plan p;
        p.kind  = PLAN_FRAME;
        p.left  = SAMPLE_W'(l);
        p.right = SAMPLE_W'(r);
        p.gap   = draw_wait(tx_calm);
        p.idx   = '0;
        p.data  = '0;
        stim_plan.push_back(p);
        frames_planned++;
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        t_plan p;
        p.kind  = PLAN_CFG;
        p.left  = '0;
        p.right = '0;
        p.gap   = 0;
        p.idx   = idx;
        p.data  = CFG_DATA_W'(data);
        stim_plan.push_back(p);
    endtask

    task automatic add_drain();
        t_plan p;
        p.kind  = PLAN_DRAIN;
        p.left  = '0;
        p.right = '0;
        p.gap   = 0;
        p.idx   = '0;
        p.data  = '0;
        stim_plan.push_back(p);
    endtask

    // Gain, mono mix and interpolation for one frame; pushes every output it causes.
    task automatic resample_frame(
        input logic signed [SAMPLE_W-1:0] l_in,
        input logic signed [SAMPLE_W-1:0] r_in
    );
        logic signed [SAMPLE_W-1:0] l;
        logic signed [SAMPLE_W-1:0] r;
        logic signed [SAMPLE_W-1:0] cur;
        logic signed [SAMPLE_W-1:0] base;
        logic signed [SAMPLE_W:0]   sum;
        logic signed [SAMPLE_W-1:0] refs[MAX_REFS];
        longint     prod;
        int         nref;
        int         cnt;
        t_frame_out o;
        l = l_in;
        r = r_in;
        nref = 0;
        if (m_mute) begin
            l = '0;
            r = '0;
        end else if (m_gain != GAIN_UNITY) begin
            l = scale_q15(l_in, m_gain);
            r = scale_q15(r_in, m_gain);
        end
        if (m_ref_en) begin
            sum = l + r;
            cur = sum[SAMPLE_W:1];
            if (!m_have_prev)
                m_prev = cur;
            base = m_prev;
            while (m_phase < ONE_Q16 && nref < MAX_REFS) begin
                prod = (longint'(cur) - longint'(base)) * longint'({1'b0, m_phase[FRAC_W-1:0]});
                refs[nref] = SAMPLE_W'(longint'(base) + (prod >>> 16));
                nref++;
                m_phase = m_phase + PHASE_W'(m_step);
            end
            if (m_phase >= ONE_Q16)
                m_phase = m_phase - ONE_Q16;
            m_prev = cur;
            m_have_prev = 1'b1;
            if (nref == 0)
                silent_frames++;
        end else begin
            m_have_prev = 1'b0;
        end
        cnt = (nref > 0) ? nref : 1;
        for (int k = 0; k < cnt; k++) begin
            o.play_valid = (k == 0);
            o.play_left  = (k == 0) ? l : '0;
            o.play_right = (k == 0) ? r : '0;
            o.ref_valid  = (k < nref);
            o.ref_sample = (k < nref) ? refs[k] : '0;
            o.last       = (k == cnt - 1);
            pending_outputs.push_back(o);
        end
        outputs_due += cnt;
        frames_done++;
        refs_total += nref;
        if (nref > refs_max)
            refs_max = nref;
    endtask

    // Driver: presents frames from the plan and writes registers only when idle.
    always @(posedge i_clk) begin : drv
        logic                       valid_n;
        logic                       we_n;
        t_plan                      head;
        int unsigned                gap_left;
        logic signed [SAMPLE_W-1:0] stage_l;
        logic signed [SAMPLE_W-1:0] stage_r;
        if (!i_rst_n) begin
            i_valid     <= 1'b0;
            i_cfg_we    <= 1'b0;
            staged      = 1'b0;
            gap_left    = 0;
            m_gain      = GAIN_UNITY;
            m_mute      = 1'b0;
            m_ref_en    = 1'b0;
            m_step      = STEP_RESET;
            m_prev      = '0;
            m_have_prev = 1'b0;
            m_phase     = '0;
        end else begin
            valid_n = i_valid;
            we_n    = 1'b0;
            if (i_valid && o_ready) begin
                resample_frame(i_left_in, i_right_in);
                valid_n = 1'b0;
            end
            if (!valid_n && !staged && stim_plan.size() != 0) begin
                head = stim_plan[0];
                if (head.kind == PLAN_FRAME) begin
                    void'(stim_plan.pop_front());
                    staged   = 1'b1;
                    gap_left = head.gap;
                    stage_l  = head.left;
                    stage_r  = head.right;
                end else if (o_ready && outputs_due == outputs_seen) begin
                    void'(stim_plan.pop_front());
                    if (head.kind == PLAN_CFG) begin
                        we_n = 1'b1;
                        i_cfg_index <= head.idx;
                        i_cfg_data  <= head.data;
                        cfg_writes++;
                        case (head.idx)
                            CFG_GAIN: m_gain = head.data[GAIN_W-1:0];
                            CFG_MUTE: m_mute = head.data[0];
                            CFG_REF_ENABLE: begin
                                m_ref_en = head.data[0];
                                m_phase  = '0;
                            end
                            CFG_STEP: begin
                                m_step  = head.data[STEP_W-1:0];
                                m_phase = '0;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            if (!valid_n && staged) begin
                if (gap_left == 0) begin
                    valid_n = 1'b1;
                    staged  = 1'b0;
                    i_left_in  <= stage_l;
                    i_right_in <= stage_r;
                end else begin
                    gap_left--;
                end
            end
            i_valid  <= valid_n;
            i_cfg_we <= we_n;
        end
    end

    // Monitor: checks each accepted output against the oldest prediction.
    always @(posedge i_clk) begin : mon
        t_frame_out  e;
        int unsigned stall;
        int unsigned res_stall;
        int          rx_count;
        bit          rx_calm;
        if (!i_rst_n) begin
            i_ready   <= 1'b1;
            res_stall = 0;
            rx_count  = 0;
            rx_calm   = 1'b0;
        end else if (res_stall != 0) begin
            i_ready <= (res_stall == 1);
            res_stall--;
        end else if (o_valid && i_ready) begin
            if (pending_outputs.size() == 0) begin
                $error("output with no frame pending: ref_sample %0d", o_ref_sample);
                errors++;
            end else begin
                e = pending_outputs.pop_front();
                outputs_seen <= outputs_seen + 1;
                if (o_play_valid !== e.play_valid) begin
                    $error("play_valid: expected %0d, got %0d", e.play_valid, o_play_valid);
                    errors++;
                end
                if (o_play_left !== e.play_left) begin
                    $error("play_left: expected %0d, got %0d", e.play_left, o_play_left);
                    errors++;
                end
                if (o_play_right !== e.play_right) begin
                    $error("play_right: expected %0d, got %0d", e.play_right, o_play_right);
                    errors++;
                end
                if (o_ref_valid !== e.ref_valid) begin
                    $error("ref_valid: expected %0d, got %0d", e.ref_valid, o_ref_valid);
                    errors++;
                end
                if (o_ref_sample !== e.ref_sample) begin
                    $error("ref_sample: expected %0d, got %0d", e.ref_sample, o_ref_sample);
                    errors++;
                end
                if (o_last !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, o_last);
                    errors++;
                end
            end
            rx_count++;
            // Alternate between long stretches of full throughput and random stalls.
            if (rx_count % 40 == 0)
                rx_calm = ($urandom_range(0, 2) == 0);
            stall = draw_wait(rx_calm);
            res_stall = stall;
            i_ready <= (stall == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles, %0d outputs outstanding",
                     cycle_count, outputs_due - outputs_seen);
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        int          n;
        int unsigned g;
        int unsigned s;
        int          l;
        bit          first;

        // Directed part: pass-through at reset settings with the extremes, then mute and a range of gains.
        add_frame(32767, 32767);
        add_frame(-32768, -32768);
        add_frame(32767, -32768);
        add_frame(0, 0);
        add_frame(-1, 1);
        add_cfg(CFG_MUTE, 1);
        add_frame(32767, -32768);
        add_frame(12345, -1);
        add_cfg(CFG_MUTE, 0);
        add_cfg(CFG_GAIN, 0);
        add_frame(32767, -32768);
        add_cfg(CFG_GAIN, 1);
        add_frame(-32768, 32767);
        add_cfg(CFG_GAIN, 16384);
        add_frame(-3, 3);
        add_cfg(CFG_GAIN, 32766);
        add_frame(-32768, 32767);
        // Reference path on: the first frame interpolates against itself.
        add_cfg(CFG_GAIN, 32767);
        add_cfg(CFG_REF_ENABLE, 1);
        add_frame(1000, 2000);
        add_frame(-32768, -32768);
        add_frame(32767, 32767);
        // Step of one eighth fills the cap exactly; one sixteenth hits it early.
        add_cfg(CFG_STEP, 8192);
        add_frame(0, 0);
        add_frame(32767, 32767);
        add_cfg(CFG_STEP, 4096);
        add_frame(-32768, 32767);
        add_cfg(CFG_STEP, 0);
        add_frame(100, -100);
        // Decimating steps, where a frame may produce no reference sample.
        add_cfg(CFG_STEP, 393216);
        add_frame(-20000, 5000);
        add_frame(30000, 30000);
        add_frame(-32768, -32768);
        add_cfg(CFG_STEP, 524287);
        add_frame(4321, -4321);
        add_cfg(CFG_REF_ENABLE, 0);
        add_frame(-7, 9);
        add_drain();

        // Random part: phases of register settings, each followed by frames.
        first = 1'b1;
        while (frames_planned < RANDOM_FRAMES) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            if (first || $urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 5))
                    0:       g = 32767;
                    1:       g = 0;
                    2:       g = 32766;
                    3:       g = 1;
                    default: g = $urandom_range(0, 32767);
                endcase
                add_cfg(CFG_GAIN, ($urandom_range(0, 15) << 15) | g);
            end
            if (first || $urandom_range(0, 1) == 0)
                add_cfg(CFG_MUTE, ($urandom_range(0, 262143) << 1)
                                  | 32'($urandom_range(0, 5) == 0));
            if (first || $urandom_range(0, 1) == 0)
                add_cfg(CFG_STEP, 0);
            if (first || $urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 9))
                    0:       s = 8192;
                    1:       s = 393216;
                    2:       s = 0;
                    3:       s = $urandom_range(1, 8191);
                    4:       s = $urandom_range(393217, 524287);
                    5:       s = 65536;
                    default: s = $urandom_range(8192, 393216);
                endcase
                add_cfg(CFG_STEP, s);
            end
            if (first || $urandom_range(0, 2) == 0)
                add_cfg(CFG_REF_ENABLE, ($urandom_range(0, 262143) << 1)
                                        | 32'($urandom_range(0, 5) != 0));
            first = 1'b0;
            n = $urandom_range(15, 35);
            for (int i = 0; i < n; i++) begin
                if (i == n / 2 && $urandom_range(0, 2) == 0)
                    add_drain();
                case ($urandom_range(0, 3))
                    0, 1: add_frame($urandom_range(0, 65535), $urandom_range(0, 65535));
                    2: begin
                        case ($urandom_range(0, 3))
                            0:       l = 32767;
                            1:       l = -32768;
                            2:       l = 0;
                            default: l = -1;
                        endcase
                        add_frame(l, $urandom_range(0, 1) ? -32768 : 32767);
                    end
                    default: begin
                        l = $urandom_range(0, 65535);
                        add_frame(l, l);
                    end
                endcase
            end
            add_drain();
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (!(stim_plan.size() == 0 && !staged && !i_valid && outputs_due == outputs_seen));
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (pending_outputs.size() != 0) begin
            $error("%0d predicted outputs never arrived", pending_outputs.size());
            errors++;
        end
        $display("tb: %0d frames, %0d outputs checked, %0d register writes, %0d errors",
                 frames_done, outputs_seen, cfg_writes, errors);
        $display("tb: %0d reference samples, up to %0d per frame, %0d frames without one",
                 refs_total, refs_max, silent_frames);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/sgmr_pkg.sv
rtl/sgmr_ctrl.sv
rtl/sgmr_dp.sv
rtl/stereo_gain_and_mono_resampler.sv
verif/tb.sv
